// ----- design/pirl_pkg.sv -----
`timescale 1ns / 1ps

package pirl_pkg;

    localparam int POS_W    = 5;
    localparam int WORD_W   = 32;
    localparam int COUNT_W  = 5;
    localparam int KIND_W   = 3;
    localparam int STATUS_W = 2;

    typedef enum logic [KIND_W-1:0] {
        REQ_INSERT_AT   = 3'd0,
        REQ_APPEND      = 3'd1,
        REQ_REMOVE_AT   = 3'd2,
        REQ_REMOVE_LAST = 3'd3,
        REQ_READ_AT     = 3'd4,
        REQ_READ_LAST   = 3'd5,
        REQ_CLEAR       = 3'd6
    } req_kind_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_RANGE = 2'd2
    } status_t;

    typedef struct packed {
        logic insert;
        logic remove;
    } cell_cmd_t;

endpackage

// ----- design/positional_insert_remove_list.sv -----
`timescale 1ns / 1ps
// result: registered, on the master side in the cycle after the input transfer
// throughput: one request per cycle while results are taken; the selection of a
// read word across the row of cells and the shift of every cell finish in that cycle
// reset: aresetn clears the entry count and the result valid; cell words stay
// undefined until written

module positional_insert_remove_list #(
    parameter int CAPACITY   = 16,
    parameter int DATA_WIDTH = 32
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // position[4:0], data_in[36:5], zero pad
    input  logic [2:0]  s_tuser,   // req_type[2:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // data_out[31:0], entry_count[36:32], zero pad
    output logic [1:0]  m_tuser    // status[1:0]
);

    localparam int CW   = $clog2(CAPACITY + 1);
    localparam int IW   = $clog2(CAPACITY);
    localparam int CMPW = (CW > pirl_pkg::POS_W) ? CW : pirl_pkg::POS_W;

    logic [CW-1:0]  used_reg;
    logic [CW-1:0]  used_next;
    logic           m_valid_reg;
    logic           m_valid_next;
    logic [pirl_pkg::STATUS_W-1:0] status_reg;
    logic [pirl_pkg::STATUS_W-1:0] status_next;
    logic [pirl_pkg::WORD_W-1:0]   dout_reg;
    logic [pirl_pkg::WORD_W-1:0]   dout_next;
    logic [pirl_pkg::COUNT_W-1:0]  count_reg;
    logic [pirl_pkg::COUNT_W-1:0]  count_next;

    logic                          accept;
    logic [pirl_pkg::POS_W-1:0]    pos;
    logic [DATA_WIDTH-1:0]         word;
    logic [CMPW-1:0]               pos_ext;
    logic [CMPW-1:0]               used_ext;
    logic                          full;
    logic                          empty;
    logic                          do_ins;
    logic                          do_rem;
    logic                          do_rd;
    logic [IW-1:0]                 idx;
    pirl_pkg::status_t             status;
    pirl_pkg::cell_cmd_t           cmd;
    logic [DATA_WIDTH-1:0]         rd_data;

    logic [DATA_WIDTH-1:0] cell_data [CAPACITY];
    logic [DATA_WIDTH-1:0] cell_tap  [CAPACITY];

    assign s_tready = !m_valid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;

    assign pos      = s_tdata[pirl_pkg::POS_W-1:0];
    assign word     = DATA_WIDTH'(s_tdata[pirl_pkg::POS_W +: pirl_pkg::WORD_W]);
    assign pos_ext  = CMPW'(pos);
    assign used_ext = CMPW'(used_reg);
    assign full     = (used_reg == CW'(CAPACITY));
    assign empty    = (used_reg == '0);

    always_comb begin
        do_ins    = 1'b0;
        do_rem    = 1'b0;
        do_rd     = 1'b0;
        idx       = '0;
        status    = pirl_pkg::ST_OK;
        used_next = used_reg;
        case (s_tuser)
            pirl_pkg::REQ_INSERT_AT, pirl_pkg::REQ_APPEND: begin
                if (full) begin
                    status = pirl_pkg::ST_FULL;
                end else begin
                    do_ins    = 1'b1;
                    used_next = used_reg + 1'b1;
                    if (s_tuser == pirl_pkg::REQ_APPEND || pos_ext >= used_ext) begin
                        idx = IW'(used_reg);
                    end else begin
                        idx = IW'(pos);
                    end
                end
            end
            pirl_pkg::REQ_REMOVE_AT, pirl_pkg::REQ_READ_AT: begin
                if (pos_ext >= used_ext) begin
                    status = pirl_pkg::ST_RANGE;
                end else begin
                    do_rd = 1'b1;
                    idx   = IW'(pos);
                    if (s_tuser == pirl_pkg::REQ_REMOVE_AT) begin
                        do_rem    = 1'b1;
                        used_next = used_reg - 1'b1;
                    end
                end
            end
            pirl_pkg::REQ_REMOVE_LAST, pirl_pkg::REQ_READ_LAST: begin
                if (empty) begin
                    status = pirl_pkg::ST_RANGE;
                end else begin
                    do_rd = 1'b1;
                    idx   = IW'(used_reg - 1'b1);
                    if (s_tuser == pirl_pkg::REQ_REMOVE_LAST) begin
                        do_rem    = 1'b1;
                        used_next = used_reg - 1'b1;
                    end
                end
            end
            pirl_pkg::REQ_CLEAR: begin
                used_next = '0;
            end
            default: begin
            end
        endcase
    end

    assign cmd.insert = accept && do_ins;
    assign cmd.remove = accept && do_rem;

    for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
        logic [DATA_WIDTH-1:0] below;
        logic [DATA_WIDTH-1:0] upper;
        if (i == 0) begin : g_first
            assign below = word;
        end else begin : g_mid
            assign below = cell_data[i-1];
        end
        if (i == CAPACITY - 1) begin : g_last
            assign upper = cell_data[i];
        end else begin : g_up
            assign upper = cell_data[i+1];
        end
        pirl_cell #(
            .DW(DATA_WIDTH),
            .IW(IW),
            .ID(i)
        ) u_cell (
            .aclk       (aclk),
            .cmd        (cmd),
            .idx        (idx),
            .word       (word),
            .below_data (below),
            .above_data (upper),
            .data       (cell_data[i]),
            .tap        (cell_tap[i])
        );
    end

    always_comb begin
        rd_data = '0;
        for (int i = 0; i < CAPACITY; i++) begin
            rd_data = rd_data | cell_tap[i];
        end
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        status_next  = status_reg;
        dout_next    = dout_reg;
        count_next   = count_reg;
        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end
        if (accept) begin
            m_valid_next = 1'b1;
            status_next  = status;
            dout_next    = do_rd ? pirl_pkg::WORD_W'(rd_data) : '0;
            count_next   = pirl_pkg::COUNT_W'(used_next);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            used_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
            if (accept) begin
                used_reg <= used_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        status_reg <= status_next;
        dout_reg   <= dout_next;
        count_reg  <= count_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = status_reg;
    assign m_tdata  = {3'b000, count_reg, dout_reg};

endmodule

// ----- design/pirl_cell.sv -----
`timescale 1ns / 1ps

module pirl_cell #(
    parameter int DW = 32,
    parameter int IW = 4,
    parameter int ID = 0
) (
    input  logic                aclk,
    input  pirl_pkg::cell_cmd_t cmd,
    input  logic [IW-1:0]       idx,
    input  logic [DW-1:0]       word,
    input  logic [DW-1:0]       below_data,
    input  logic [DW-1:0]       above_data,
    output logic [DW-1:0]       data,
    output logic [DW-1:0]       tap
);

    logic [DW-1:0] data_reg;
    logic [DW-1:0] data_next;
    logic          hit;
    logic          above;

    assign hit   = (IW'(ID) == idx);
    assign above = (IW'(ID) > idx);

    always_comb begin
        data_next = data_reg;
        if (cmd.insert) begin
            if (hit) begin
                data_next = word;
            end else if (above) begin
                data_next = below_data;
            end
        end else if (cmd.remove) begin
            if (hit || above) begin
                data_next = above_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        data_reg <= data_next;
    end

    assign data = data_reg;
    assign tap  = hit ? data_reg : '0;

endmodule

// ----- test/positional_insert_remove_list_test.sv -----
`timescale 1ns / 1ps

module positional_insert_remove_list_test;

    localparam int CAPACITY    = 16;
    localparam int RAND_ITEMS  = 1030;
    localparam int HOLD_AT     = 200;
    localparam int HOLD_CYCLES = 300;
    localparam int PAUSE_AT    = 700;
    localparam int TAIL_CYCLES = 10;
    localparam int CYCLE_LIMIT = 600000;

    localparam logic [pirl_pkg::KIND_W-1:0] REQ_UNUSED = 3'd7;

    typedef struct {
        logic [pirl_pkg::KIND_W-1:0] kind;
        logic [pirl_pkg::POS_W-1:0]  pos;
        logic [pirl_pkg::WORD_W-1:0] word;
    } list_req_t;

    typedef struct {
        pirl_pkg::status_t            status;
        logic [pirl_pkg::WORD_W-1:0]  word;
        logic [pirl_pkg::COUNT_W-1:0] count;
    } list_result_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [39:0] s_tdata = '0;
    logic [2:0]  s_tuser = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [39:0] m_tdata;
    logic [1:0]  m_tuser;

    positional_insert_remove_list #(
        .CAPACITY  (CAPACITY),
        .DATA_WIDTH(pirl_pkg::WORD_W)
    ) dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tuser (m_tuser)
    );

    list_req_t    pending_reqs[$];
    list_result_t expected_results[$];

    logic [pirl_pkg::WORD_W-1:0] list_words[CAPACITY];
    int                          list_used = 0;

    int error_cnt = 0;
    int sent_cnt = 0;
    int send_gap = 0;
    int rx_stall = 0;
    int hold_left = 0;
    bit hold_done = 0;
    int cycle_cnt = 0;

    // weights per mix: insert_at, append, remove_at, remove_last,
    // read_at, read_last, clear, unused code
    int kind_weight[3][8] = '{
        '{40, 35, 5, 5, 7, 5, 1, 2},
        '{10, 10, 30, 20, 18, 9, 1, 2},
        '{25, 20, 15, 10, 15, 10, 3, 2}
    };

    initial begin
        forever #5 aclk = ~aclk;
    end

    task automatic insert_word(input int idx, input logic [pirl_pkg::WORD_W-1:0] w,
                               output pirl_pkg::status_t st);
        int i;
        st = pirl_pkg::ST_OK;
        if (list_used >= CAPACITY) begin
            st = pirl_pkg::ST_FULL;
        end else begin
            if (idx > list_used) idx = list_used;
            for (i = list_used; i > idx; i--) list_words[i] = list_words[i-1];
            list_words[idx] = w;
            list_used++;
        end
    endtask

    task automatic take_word(input int idx, output logic [pirl_pkg::WORD_W-1:0] w,
                             output pirl_pkg::status_t st);
        int i;
        w = '0;
        st = pirl_pkg::ST_RANGE;
        if (idx < list_used) begin
            w = list_words[idx];
            for (i = idx; i + 1 < list_used; i++) list_words[i] = list_words[i+1];
            list_used--;
            st = pirl_pkg::ST_OK;
        end
    endtask

    task automatic peek_word(input int idx, output logic [pirl_pkg::WORD_W-1:0] w,
                             output pirl_pkg::status_t st);
        w = '0;
        st = pirl_pkg::ST_RANGE;
        if (idx < list_used) begin
            w = list_words[idx];
            st = pirl_pkg::ST_OK;
        end
    endtask

    task automatic apply_request(input list_req_t r, output list_result_t res);
        pirl_pkg::status_t           st;
        logic [pirl_pkg::WORD_W-1:0] w;
        st = pirl_pkg::ST_OK;
        w = '0;
        case (r.kind)
            pirl_pkg::REQ_INSERT_AT:   insert_word(int'(r.pos), r.word, st);
            pirl_pkg::REQ_APPEND:      insert_word(list_used, r.word, st);
            pirl_pkg::REQ_REMOVE_AT:   take_word(int'(r.pos), w, st);
            pirl_pkg::REQ_REMOVE_LAST: begin
                if (list_used == 0) st = pirl_pkg::ST_RANGE;
                else take_word(list_used - 1, w, st);
            end
            pirl_pkg::REQ_READ_AT:     peek_word(int'(r.pos), w, st);
            pirl_pkg::REQ_READ_LAST: begin
                if (list_used == 0) st = pirl_pkg::ST_RANGE;
                else peek_word(list_used - 1, w, st);
            end
            pirl_pkg::REQ_CLEAR:       list_used = 0;
            default: ;
        endcase
        if (st != pirl_pkg::ST_OK) w = '0;
        res.status = st;
        res.word = w;
        res.count = pirl_pkg::COUNT_W'(list_used);
    endtask

    task automatic report_mismatch(input string field, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("mismatch on %s at cycle %0d: got 0x%0h, want 0x%0h",
                 field, cycle_cnt, got, want);
        error_cnt++;
    endtask

    task automatic queue_req(input logic [pirl_pkg::KIND_W-1:0] kind, input int pos,
                             input logic [pirl_pkg::WORD_W-1:0] word);
        list_req_t r;
        r.kind = kind;
        r.pos = pirl_pkg::POS_W'(pos);
        r.word = word;
        pending_reqs.push_back(r);
    endtask

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [pirl_pkg::KIND_W-1:0] pick_kind(input int mix);
        int r;
        int acc;
        int k;
        r = $urandom_range(0, 99);
        acc = 0;
        for (k = 0; k < 8; k++) begin
            acc += kind_weight[mix][k];
            if (r < acc) return pirl_pkg::KIND_W'(k);
        end
        return REQ_UNUSED;
    endfunction

    // sender
    always @(posedge aclk) begin
        list_req_t    r;
        list_result_t res;
        logic         offer;
        bit           quiet;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            quiet = ((sent_cnt / 150) % 4) == 3;
            if (s_tvalid && s_tready) begin
                r = pending_reqs.pop_front();
                apply_request(r, res);
                expected_results.push_back(res);
                sent_cnt++;
                send_gap = quiet ? 0 : pick_gap();
            end
            offer = s_tvalid && !s_tready;
            if (!offer) begin
                if (send_gap > 0) begin
                    send_gap--;
                end else if (sent_cnt == PAUSE_AT && expected_results.size() != 0) begin
                    offer = 1'b0;
                end else if (pending_reqs.size() != 0) begin
                    offer = 1'b1;
                    s_tdata <= {3'b000, pending_reqs[0].word, pending_reqs[0].pos};
                    s_tuser <= pending_reqs[0].kind;
                end
            end
            s_tvalid <= offer;
        end
    end

    // receiver and checker
    always @(posedge aclk) begin
        list_result_t want;
        logic         rdy;
        bit           quiet;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            quiet = ((sent_cnt / 150) % 4) == 3;
            if (m_tvalid && m_tready) begin
                if (expected_results.size() == 0) begin
                    $display("unexpected result transfer at cycle %0d", cycle_cnt);
                    error_cnt++;
                end else begin
                    want = expected_results.pop_front();
                    if (m_tuser !== want.status)
                        report_mismatch("status", 32'(m_tuser), 32'(want.status));
                    if (m_tdata[31:0] !== want.word)
                        report_mismatch("data_out", m_tdata[31:0], want.word);
                    if (m_tdata[36:32] !== want.count)
                        report_mismatch("entry_count", 32'(m_tdata[36:32]), 32'(want.count));
                end
            end
            if (hold_left > 0) begin
                hold_left--;
                rdy = 1'b0;
            end else if (!hold_done && sent_cnt >= HOLD_AT) begin
                hold_done = 1;
                hold_left = HOLD_CYCLES - 1;
                rdy = 1'b0;
            end else if (rx_stall > 0) begin
                rx_stall--;
                rdy = 1'b0;
            end else if (quiet) begin
                rdy = 1'b1;
            end else begin
                rx_stall = pick_gap();
                rdy = (rx_stall == 0);
                if (rx_stall > 0) rx_stall--;
            end
            m_tready <= rdy;
        end
    end

    always @(posedge aclk) begin
        cycle_cnt++;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("positional_insert_remove_list_test: errors");
            $finish;
        end
    end

    initial begin
        int n;
        int mix;
        int pos;

        // empty list corners
        queue_req(pirl_pkg::REQ_READ_LAST, 0, 32'h1234_5678);
        queue_req(pirl_pkg::REQ_REMOVE_LAST, 3, 32'h0);
        queue_req(pirl_pkg::REQ_REMOVE_AT, 31, 32'hFFFF_FFFF);
        queue_req(REQ_UNUSED, 5, 32'hDEAD_BEEF);
        queue_req(pirl_pkg::REQ_INSERT_AT, 0, 32'hFFFF_FFFF);
        queue_req(pirl_pkg::REQ_INSERT_AT, 31, 32'h0000_0000);
        queue_req(pirl_pkg::REQ_INSERT_AT, 1, 32'hA5A5_5A5A);
        queue_req(pirl_pkg::REQ_READ_AT, 3, 32'h0);
        queue_req(pirl_pkg::REQ_READ_AT, 0, 32'h0);
        queue_req(pirl_pkg::REQ_REMOVE_AT, 1, 32'h0);
        // fill to capacity, then refused inserts
        for (n = 0; n < CAPACITY - 2; n++) queue_req(pirl_pkg::REQ_APPEND, n, $urandom);
        queue_req(pirl_pkg::REQ_INSERT_AT, 0, 32'h5555_AAAA);
        queue_req(pirl_pkg::REQ_APPEND, 16, 32'hAAAA_5555);
        queue_req(pirl_pkg::REQ_READ_LAST, 0, 32'h0);
        queue_req(pirl_pkg::REQ_CLEAR, 16, 32'hFFFF_FFFF);

        mix = 0;
        for (n = 0; n < RAND_ITEMS; n++) begin
            if (n % 40 == 0) mix = $urandom_range(0, 2);
            if ($urandom_range(0, 99) < 80) pos = $urandom_range(0, 16);
            else pos = $urandom_range(0, 31);
            queue_req(pick_kind(mix), pos, $urandom);
        end

        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        while (pending_reqs.size() != 0 || expected_results.size() != 0) @(posedge aclk);
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (error_cnt == 0) begin
            $display("positional_insert_remove_list_test: clean");
        end else begin
            $display("positional_insert_remove_list_test: errors");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
design/pirl_pkg.sv
design/pirl_cell.sv
design/positional_insert_remove_list.sv
test/positional_insert_remove_list_test.sv
